// ===== hdl/rtsd_pkg.sv =====
// ---------------------------------------------------------------------------
// rtsd_pkg
// Types and constants shared by the text-screen run decoder.
// ---------------------------------------------------------------------------
package rtsd_pkg;

    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_START_FG = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_START_BG = CFG_INDEX_W'(1);

    localparam logic [3:0] FG_RESET  = 4'd7;
    localparam logic [3:0] BG_RESET  = 4'd0;
    localparam logic [3:0] BLINK_BIT = 4'h8;

    localparam logic [7:0] BG_FIRST        = 8'd16;
    localparam logic [7:0] CMD_NEWLINE     = 8'd24;
    localparam logic [7:0] CMD_SPACES      = 8'd25;
    localparam logic [7:0] CMD_REPEAT      = 8'd26;
    localparam logic [7:0] CMD_BLINK       = 8'd27;
    localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
    localparam logic [7:0] SPACE_CHAR      = 8'd32;

    typedef enum logic [4:0] {
        PH_NORMAL      = 5'b00001,
        PH_SPACE_COUNT = 5'b00010,
        PH_REP_COUNT   = 5'b00100,
        PH_REP_CHAR    = 5'b01000,
        PH_SKIP        = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [6:0] start_column;
        logic [4:0] row;
        logic [7:0] character;
        logic [7:0] attribute;
        logic [8:0] run_length;
    } run_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } stage_t;

    typedef struct packed {
        logic [3:0] start_fg;
        logic [3:0] start_bg;
    } start_colors_t;

endpackage

// ===== hdl/rtsd_byte_if.sv =====
// ---------------------------------------------------------------------------
// rtsd_byte_if
// Input byte channel: valid/ready with one stream byte and its end mark.
// ---------------------------------------------------------------------------
interface rtsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== hdl/rtsd_run_if.sv =====
// ---------------------------------------------------------------------------
// rtsd_run_if
// Output run channel: valid/ready with one cell-fill run.
// ---------------------------------------------------------------------------
interface rtsd_run_if;
    logic       valid;
    logic       ready;
    logic [6:0] start_column;
    logic [4:0] row;
    logic [7:0] character;
    logic [7:0] attribute;
    logic [8:0] run_length;

    modport source (
        output valid, output start_column, output row, output character,
        output attribute, output run_length, input ready
    );
    modport sink (
        input valid, input start_column, input row, input character,
        input attribute, input run_length, output ready
    );
endinterface

// ===== hdl/rtsd_cfg_if.sv =====
// ---------------------------------------------------------------------------
// rtsd_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ---------------------------------------------------------------------------
interface rtsd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rtsd_pkg::CFG_INDEX_W-1:0] index;
    logic [3:0]                       data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/rtsd_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// rtsd_cfg_regs
// Start colour registers, written over the configuration channel.
// ---------------------------------------------------------------------------
module rtsd_cfg_regs (
    input  logic                  clk,
    input  logic                  rst_n,
    rtsd_cfg_if.sink              cfg,
    output rtsd_pkg::start_colors_t colors
);

    logic [3:0] start_fg_reg;
    logic [3:0] start_bg_reg;

    assign cfg.ready       = 1'b1;
    assign colors.start_fg = start_fg_reg;
    assign colors.start_bg = start_bg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_fg_reg <= rtsd_pkg::FG_RESET;
            start_bg_reg <= rtsd_pkg::BG_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == rtsd_pkg::REG_START_FG)
            begin
                start_fg_reg <= cfg.data;
            end
            if (cfg.index == rtsd_pkg::REG_START_BG)
            begin
                start_bg_reg <= cfg.data;
            end
        end
    end

endmodule

// ===== hdl/rtsd_in_stage.sv =====
// ---------------------------------------------------------------------------
// rtsd_in_stage
// Input register: hold one accepted byte until the decoder takes it.
// ---------------------------------------------------------------------------
module rtsd_in_stage (
    input  logic             clk,
    input  logic             rst_n,
    rtsd_byte_if.sink        byte_stream,
    input  logic             taken,
    output rtsd_pkg::stage_t stage
);

    logic            valid_reg;
    logic            valid_next;
    rtsd_pkg::item_t item_reg;
    logic            load;

    assign byte_stream.ready = !valid_reg || taken;
    assign load              = byte_stream.valid && byte_stream.ready;
    assign valid_next        = load || (valid_reg && !taken);

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.data_byte <= byte_stream.data_byte;
            item_reg.last_byte <= byte_stream.last_byte;
        end
    end

endmodule

// ===== hdl/rtsd_decode.sv =====
// ---------------------------------------------------------------------------
// rtsd_decode
// Parser state, one-byte decode and the result register.
// ---------------------------------------------------------------------------
module rtsd_decode #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rtsd_pkg::stage_t        stage,
    input  rtsd_pkg::start_colors_t colors,
    output logic                    taken,
    rtsd_run_if.source              run_stream
);

    localparam logic [7:0] COLS_8    = 8'(SCREEN_COLUMNS);
    localparam logic [5:0] ROWS_6    = 6'(SCREEN_ROWS);
    localparam logic [4:0] LAST_ROW  = 5'(SCREEN_ROWS - 1);

    // (count + 1) mod columns for every count byte
    logic [6:0] len_mod [256];

    for (genvar g = 0; g < 256; g++)
    begin : g_len_mod
        assign len_mod[g] = 7'((g + 1) % SCREEN_COLUMNS);
    end

    rtsd_pkg::phase_t phase_reg, phase_next;
    logic [6:0]       col_reg, col_next;
    logic [4:0]       row_reg, row_next;
    logic [3:0]       fg_reg, fg_next;
    logic [3:0]       bg_reg, bg_next;
    logic [7:0]       pend_reg, pend_next;
    logic             res_valid_reg, res_valid_next;
    rtsd_pkg::run_t   res_reg, res_next;

    logic       out_free;
    logic       emit;
    logic [7:0] c;
    logic [7:0] run_char;
    logic [7:0] run_cnt;
    logic [7:0] col_sum;
    logic [6:0] col_adv;

    assign out_free = !res_valid_reg || run_stream.ready;
    assign taken    = stage.valid && out_free;
    assign c        = stage.item.data_byte;

    assign col_sum = {1'b0, col_reg} + {1'b0, len_mod[run_cnt]};
    assign col_adv = (col_sum >= COLS_8) ? 7'(col_sum - COLS_8) : col_sum[6:0];

    always_comb
    begin
        phase_next = phase_reg;
        row_next   = row_reg;
        fg_next    = fg_reg;
        bg_next    = bg_reg;
        pend_next  = pend_reg;
        emit       = 1'b0;
        run_char   = c;
        run_cnt    = 8'd0;

        unique case (phase_reg)
            rtsd_pkg::PH_SPACE_COUNT:
            begin
                emit       = 1'b1;
                run_char   = rtsd_pkg::SPACE_CHAR;
                run_cnt    = c;
                phase_next = rtsd_pkg::PH_NORMAL;
            end
            rtsd_pkg::PH_REP_COUNT:
            begin
                pend_next  = c;
                phase_next = rtsd_pkg::PH_REP_CHAR;
            end
            rtsd_pkg::PH_REP_CHAR:
            begin
                emit       = 1'b1;
                run_cnt    = pend_reg;
                phase_next = rtsd_pkg::PH_NORMAL;
            end
            rtsd_pkg::PH_SKIP:
            begin
                phase_next = rtsd_pkg::PH_NORMAL;
            end
            default:
            begin
                priority if (c >= rtsd_pkg::FIRST_PRINTABLE)
                begin
                    emit = 1'b1;
                end
                else if (c < rtsd_pkg::BG_FIRST)
                begin
                    fg_next = c[3:0];
                end
                else if (c < rtsd_pkg::CMD_NEWLINE)
                begin
                    bg_next = (bg_reg & rtsd_pkg::BLINK_BIT) | {1'b0, c[2:0]};
                end
                else if (c == rtsd_pkg::CMD_NEWLINE)
                begin
                    if (({1'b0, row_reg} + 6'd1) < ROWS_6)
                    begin
                        row_next = row_reg + 5'd1;
                    end
                    else
                    begin
                        row_next = LAST_ROW;
                    end
                end
                else if (c == rtsd_pkg::CMD_SPACES)
                begin
                    phase_next = rtsd_pkg::PH_SPACE_COUNT;
                end
                else if (c == rtsd_pkg::CMD_REPEAT)
                begin
                    phase_next = rtsd_pkg::PH_REP_COUNT;
                end
                else if (c == rtsd_pkg::CMD_BLINK)
                begin
                    bg_next = bg_reg ^ rtsd_pkg::BLINK_BIT;
                end
                else
                begin
                    phase_next = rtsd_pkg::PH_SKIP;
                end
            end
        endcase

        col_next = col_reg;
        if (emit)
        begin
            col_next = col_adv;
        end
        else if ((phase_reg == rtsd_pkg::PH_NORMAL) && (c == rtsd_pkg::CMD_NEWLINE))
        begin
            col_next = 7'd0;
        end

        res_next.start_column = col_reg;
        res_next.row          = row_reg;
        res_next.character    = run_char;
        res_next.attribute    = {bg_reg, fg_reg};
        res_next.run_length   = {1'b0, run_cnt} + 9'd1;

        if (stage.item.last_byte)
        begin
            phase_next = rtsd_pkg::PH_NORMAL;
            col_next   = 7'd0;
            row_next   = 5'd0;
            fg_next    = colors.start_fg;
            bg_next    = colors.start_bg;
            pend_next  = 8'd0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (taken)
        begin
            res_valid_next = emit;
        end
        else if (run_stream.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= rtsd_pkg::PH_NORMAL;
            col_reg       <= 7'd0;
            row_reg       <= 5'd0;
            fg_reg        <= rtsd_pkg::FG_RESET;
            bg_reg        <= rtsd_pkg::BG_RESET;
            pend_reg      <= 8'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (taken)
            begin
                phase_reg <= phase_next;
                col_reg   <= col_next;
                row_reg   <= row_next;
                fg_reg    <= fg_next;
                bg_reg    <= bg_next;
                pend_reg  <= pend_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (taken && emit)
        begin
            res_reg <= res_next;
        end
    end

    assign run_stream.valid        = res_valid_reg;
    assign run_stream.start_column = res_reg.start_column;
    assign run_stream.row          = res_reg.row;
    assign run_stream.character    = res_reg.character;
    assign run_stream.attribute    = res_reg.attribute;
    assign run_stream.run_length   = res_reg.run_length;

endmodule

// ===== hdl/rle_text_screen_decoder.sv =====
// ---------------------------------------------------------------------------
// rle_text_screen_decoder
// Decode a run-length compressed text-screen byte stream into cell runs.
// ---------------------------------------------------------------------------
// Bytes enter on byte_stream (data_byte, last_byte); each transfer is one
// stream byte. Cell-fill runs leave on run_stream: start column, row,
// character, attribute and run length. Printable bytes and completed space
// or repeat commands give one run; colour, newline and prefix bytes give none.
// cfg writes the start foreground (index 0) and start background (index 1);
// they apply at reset-free restarts, i.e. after a byte marked last_byte.
// A run passes from the input register through the decode stage into the
// result register, which presents it on run_stream.
// Throughput: one byte per cycle while run_stream does not stall, set by the
// single decode stage between the input register and the result register.
// Reset clears the parser to the normal phase at row 0, column 0, with
// foreground 7 and background 0, and empties both registers.
// When run_stream stalls, the result register holds its run, the decoder
// holds, and byte_stream takes at most one more byte into the input register
// before ready drops.
// ---------------------------------------------------------------------------
module rle_text_screen_decoder #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25
) (
    input  logic       clk,
    input  logic       rst_n,
    rtsd_byte_if.sink  byte_stream,
    rtsd_run_if.source run_stream,
    rtsd_cfg_if.sink   cfg
);

    rtsd_pkg::start_colors_t colors;
    rtsd_pkg::stage_t        stage;
    logic                    taken;

    rtsd_cfg_regs u_cfg_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .colors (colors)
    );

    rtsd_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .taken       (taken),
        .stage       (stage)
    );

    rtsd_decode #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS)
    ) u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .stage      (stage),
        .colors     (colors),
        .taken      (taken),
        .run_stream (run_stream)
    );

endmodule

// ===== hdl/rtsd_checker.sv =====
// ---------------------------------------------------------------------------
// rtsd_checker
// Port-level checks on the text-screen run decoder, bound to the top level.
// ---------------------------------------------------------------------------
module rtsd_checker #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25
) (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] start_column,
    input logic [4:0] row,
    input logic [8:0] run_length
);

    logic in_xfer;

    assign in_xfer = in_valid && in_ready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("run dropped while stalled");

    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_xfer, 2))
        else $error("run appeared without a byte transfer two cycles earlier");

    a_column: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (run_length != 9'd0) && (start_column < 7'(SCREEN_COLUMNS)))
        else $error("run column or length out of range");

    a_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> row < 5'(SCREEN_ROWS))
        else $error("run row beyond last row");

endmodule

bind rle_text_screen_decoder rtsd_checker #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
) u_rtsd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (byte_stream.valid),
    .in_ready     (byte_stream.ready),
    .out_valid    (run_stream.valid),
    .out_ready    (run_stream.ready),
    .start_column (run_stream.start_column),
    .row          (run_stream.row),
    .run_length   (run_stream.run_length)
);

// ===== tb/sv/rle_text_screen_decoder_tb.sv =====
// ---------------------------------------------------------------------------
// rle_text_screen_decoder_tb
// Self-checking testbench for the text-screen run decoder.
// A directed table (extremes, every byte class, reserved skips, truncated
// commands) is followed by phases of random command streams with set or random
// start colours. A predictor follows every byte transfer and queues the run it
// should produce. Each run transfer is compared field by field with the oldest
// queued run. Both channels idle at random, and one long output hold-off
// backs up the input.
// ---------------------------------------------------------------------------
module rle_text_screen_decoder_tb;

    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;

    localparam int RANDOM_PHASES    = 8;
    localparam int BYTES_PER_PHASE  = 90;
    localparam int PRESSURE_BYTES   = 250;
    localparam int LONG_HOLD        = 300;
    localparam int SETTLE_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT   = 2000;

    localparam logic [rtsd_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = rtsd_pkg::CFG_INDEX_W'(2);
    localparam logic [rtsd_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = rtsd_pkg::CFG_INDEX_W'(3);

    localparam logic [7:0] RESERVED_FIRST = 8'd28;
    localparam logic [7:0] RESERVED_LAST  = 8'd31;

    typedef struct packed {
        logic           [7:0] data_byte;
        logic                 last_byte;
        logic                 typed;
        rtsd_pkg::run_t       run;
    } stim_row_t;

    localparam rtsd_pkg::run_t NO_RUN = '0;
    localparam int             DIRECTED_LEN = 27;

    localparam stim_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
        {8'd65, 1'b0, 1'b1, 7'd0, 5'd0, 8'd65, 8'h07, 9'd1},
        {8'd255, 1'b0, 1'b1, 7'd1, 5'd0, 8'd255, 8'h07, 9'd1},
        {rtsd_pkg::SPACE_CHAR, 1'b0, 1'b1, 7'd2, 5'd0, rtsd_pkg::SPACE_CHAR, 8'h07, 9'd1},
        {8'd0, 1'b0, 1'b0, NO_RUN},
        {8'd15, 1'b0, 1'b0, NO_RUN},
        {rtsd_pkg::BG_FIRST, 1'b0, 1'b0, NO_RUN},
        {8'd23, 1'b0, 1'b0, NO_RUN},
        {rtsd_pkg::CMD_BLINK, 1'b0, 1'b0, NO_RUN},
        {8'd20, 1'b0, 1'b0, NO_RUN},
        {8'd33, 1'b0, 1'b0, NO_RUN},
        {rtsd_pkg::CMD_SPACES, 1'b0, 1'b0, NO_RUN},
        {8'd255, 1'b0, 1'b1, 7'd4, 5'd0, rtsd_pkg::SPACE_CHAR, 8'hCF, 9'd256},
        {rtsd_pkg::CMD_REPEAT, 1'b0, 1'b0, NO_RUN},
        {8'd0, 1'b0, 1'b0, NO_RUN},
        {8'd0, 1'b0, 1'b0, NO_RUN},
        {RESERVED_FIRST, 1'b0, 1'b0, NO_RUN},
        {rtsd_pkg::CMD_SPACES, 1'b0, 1'b0, NO_RUN},
        {RESERVED_LAST, 1'b0, 1'b0, NO_RUN},
        {8'd65, 1'b0, 1'b0, NO_RUN},
        {rtsd_pkg::CMD_NEWLINE, 1'b0, 1'b0, NO_RUN},
        {rtsd_pkg::CMD_REPEAT, 1'b0, 1'b0, NO_RUN},
        {8'd255, 1'b0, 1'b0, NO_RUN},
        {8'd90, 1'b0, 1'b0, NO_RUN},
        {rtsd_pkg::CMD_SPACES, 1'b0, 1'b0, NO_RUN},
        {8'd4, 1'b1, 1'b0, NO_RUN},
        {rtsd_pkg::CMD_REPEAT, 1'b0, 1'b0, NO_RUN},
        {8'd3, 1'b1, 1'b0, NO_RUN}
    };

    logic clk;
    logic rst_n;

    rtsd_byte_if byte_if ();
    rtsd_run_if  run_if ();
    rtsd_cfg_if  cfg_if ();

    rle_text_screen_decoder #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_if),
        .run_stream  (run_if),
        .cfg         (cfg_if)
    );

    logic              typed_run_en;
    rtsd_pkg::run_t    typed_run;
    rtsd_pkg::run_t    runs_due[$];
    bit                failed;
    bit                steady_send;
    bit                long_hold_req;
    int unsigned       bytes_sent;
    int unsigned       idle_cycles;

    rtsd_pkg::phase_t  cur_phase;
    logic [6:0]        cur_col;
    logic [4:0]        cur_row;
    logic [3:0]        cur_fg;
    logic [3:0]        cur_bg;
    logic [7:0]        rep_count;
    logic [3:0]        start_fg;
    logic [3:0]        start_bg;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic start_picture();
        cur_phase = rtsd_pkg::PH_NORMAL;
        cur_col   = '0;
        cur_row   = '0;
        cur_fg    = start_fg;
        cur_bg    = start_bg;
        rep_count = '0;
    endtask

    task automatic fill_run(input logic [7:0] ch, input int unsigned len,
                            output rtsd_pkg::run_t run);
        run.start_column = cur_col;
        run.row          = cur_row;
        run.character    = ch;
        run.attribute    = {cur_bg, cur_fg};
        run.run_length   = 9'(len);
        cur_col = 7'((int'(cur_col) + len) % SCREEN_COLUMNS);
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic last,
                               output bit got, output rtsd_pkg::run_t run);
        got = 1'b0;
        run = NO_RUN;
        case (cur_phase)
            rtsd_pkg::PH_SPACE_COUNT:
            begin
                fill_run(rtsd_pkg::SPACE_CHAR, int'(b) + 1, run);
                got = 1'b1;
                cur_phase = rtsd_pkg::PH_NORMAL;
            end
            rtsd_pkg::PH_REP_COUNT:
            begin
                rep_count = b;
                cur_phase = rtsd_pkg::PH_REP_CHAR;
            end
            rtsd_pkg::PH_REP_CHAR:
            begin
                fill_run(b, int'(rep_count) + 1, run);
                got = 1'b1;
                cur_phase = rtsd_pkg::PH_NORMAL;
            end
            rtsd_pkg::PH_SKIP:
                cur_phase = rtsd_pkg::PH_NORMAL;
            default:
            begin
                if (b >= rtsd_pkg::FIRST_PRINTABLE)
                begin
                    fill_run(b, 1, run);
                    got = 1'b1;
                end
                else if (b < rtsd_pkg::BG_FIRST)
                    cur_fg = b[3:0];
                else if (b < rtsd_pkg::CMD_NEWLINE)
                    cur_bg = (cur_bg & rtsd_pkg::BLINK_BIT) | 4'(b - rtsd_pkg::BG_FIRST);
                else if (b == rtsd_pkg::CMD_NEWLINE)
                begin
                    cur_col = '0;
                    if (int'(cur_row) + 1 < SCREEN_ROWS)
                        cur_row = cur_row + 5'd1;
                    else
                        cur_row = 5'(SCREEN_ROWS - 1);
                end
                else if (b == rtsd_pkg::CMD_SPACES)
                    cur_phase = rtsd_pkg::PH_SPACE_COUNT;
                else if (b == rtsd_pkg::CMD_REPEAT)
                    cur_phase = rtsd_pkg::PH_REP_COUNT;
                else if (b == rtsd_pkg::CMD_BLINK)
                    cur_bg = cur_bg ^ rtsd_pkg::BLINK_BIT;
                else
                    cur_phase = rtsd_pkg::PH_SKIP;
            end
        endcase
        if (last)
            start_picture();
    endtask

    function automatic void check_field(string name, int unsigned want, int unsigned seen);
        if (want != seen)
        begin
            $error("%s: expected %0d, actual %0d", name, want, seen);
            failed = 1'b1;
        end
    endfunction

    always @(posedge clk)
    begin : monitor
        rtsd_pkg::run_t want;
        rtsd_pkg::run_t next_run;
        bit             got;
        if (rst_n)
        begin
            if (run_if.valid && run_if.ready)
            begin
                if (runs_due.size() == 0)
                begin
                    $error("run transfer with none expected: column %0d row %0d char %0d",
                           run_if.start_column, run_if.row, run_if.character);
                    failed = 1'b1;
                end
                else
                begin
                    want = runs_due.pop_front();
                    check_field("start_column", want.start_column, run_if.start_column);
                    check_field("row", want.row, run_if.row);
                    check_field("character", want.character, run_if.character);
                    check_field("attribute", want.attribute, run_if.attribute);
                    check_field("run_length", want.run_length, run_if.run_length);
                end
            end
            if (cfg_if.valid && cfg_if.ready)
            begin
                if (cfg_if.index == rtsd_pkg::REG_START_FG)
                    start_fg = cfg_if.data;
                else if (cfg_if.index == rtsd_pkg::REG_START_BG)
                    start_bg = cfg_if.data;
            end
            if (byte_if.valid && byte_if.ready)
            begin
                decode_byte(byte_if.data_byte, byte_if.last_byte, got, next_run);
                if (typed_run_en)
                    runs_due.push_back(typed_run);
                else if (got)
                    runs_due.push_back(next_run);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((byte_if.valid && byte_if.ready) || (run_if.valid && run_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL rle_text_screen_decoder");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_count();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 8'($urandom_range(0, 15));
        if (r < 85)
            return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    initial
    begin : receiver
        int unsigned stall;
        run_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                run_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                stall = pick_gap();
                if (stall != 0)
                begin
                    run_if.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                run_if.ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last,
                             input logic typed, input rtsd_pkg::run_t run);
        int unsigned gap;
        byte_if.valid     <= 1'b1;
        byte_if.data_byte <= b;
        byte_if.last_byte <= last;
        typed_run_en      <= typed;
        typed_run         <= run;
        do
            @(posedge clk);
        while (byte_if.ready !== 1'b1);
        bytes_sent++;
        gap = steady_send ? 0 : pick_gap();
        if (gap != 0)
        begin
            byte_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_token();
        int unsigned r;
        logic [7:0]  seq[$];
        r = $urandom_range(0, 99);
        if (r < 45)
            seq.push_back(8'($urandom_range(32, 255)));
        else if (r < 55)
            seq.push_back(8'($urandom_range(0, 15)));
        else if (r < 63)
            seq.push_back(8'($urandom_range(16, 23)));
        else if (r < 67)
            seq.push_back(rtsd_pkg::CMD_NEWLINE);
        else if (r < 75)
        begin
            seq.push_back(rtsd_pkg::CMD_SPACES);
            seq.push_back(pick_count());
        end
        else if (r < 83)
        begin
            seq.push_back(rtsd_pkg::CMD_REPEAT);
            seq.push_back(pick_count());
            seq.push_back(8'($urandom_range(0, 255)));
        end
        else if (r < 87)
            seq.push_back(rtsd_pkg::CMD_BLINK);
        else if (r < 91)
        begin
            seq.push_back(8'($urandom_range(int'(RESERVED_FIRST), int'(RESERVED_LAST))));
            seq.push_back(8'($urandom_range(0, 255)));
        end
        else if (r < 92)
            repeat (SCREEN_ROWS + 2) seq.push_back(rtsd_pkg::CMD_NEWLINE);
        else
            seq.push_back(8'($urandom_range(0, 255)));
        foreach (seq[i])
            send_byte(seq[i], $urandom_range(0, 59) == 0, 1'b0, NO_RUN);
    endtask

    task automatic write_reg(input logic [rtsd_pkg::CFG_INDEX_W-1:0] index,
                             input logic [3:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= index;
        cfg_if.data  <= data;
        do
            @(posedge clk);
        while (cfg_if.ready !== 1'b1);
    endtask

    task automatic program_colors(input logic [3:0] fg, input logic [3:0] bg);
        write_reg(rtsd_pkg::REG_START_FG, fg);
        write_reg(rtsd_pkg::REG_START_BG, bg);
        write_reg(REG_SPARE_A, ~fg);
        write_reg(REG_SPARE_B, ~bg);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic settle();
        byte_if.valid <= 1'b0;
        while (runs_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        stim_row_t   row_item;
        int unsigned target;
        logic [3:0]  fg;
        logic [3:0]  bg;
        rst_n             = 1'b0;
        byte_if.valid     = 1'b0;
        byte_if.data_byte = '0;
        byte_if.last_byte = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = '0;
        cfg_if.data       = '0;
        typed_run_en      = 1'b0;
        typed_run         = NO_RUN;
        failed            = 1'b0;
        steady_send       = 1'b0;
        long_hold_req     = 1'b0;
        bytes_sent        = 0;
        idle_cycles       = 0;
        start_fg          = rtsd_pkg::FG_RESET;
        start_bg          = rtsd_pkg::BG_RESET;
        start_picture();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        program_colors(4'hF, 4'hF);
        for (int i = 0; i < DIRECTED_LEN; i++)
        begin
            row_item = DIRECTED_ROWS[i];
            send_byte(row_item.data_byte, row_item.last_byte, row_item.typed, row_item.run);
        end
        repeat (SCREEN_ROWS + 5) send_byte(rtsd_pkg::CMD_NEWLINE, 1'b0, 1'b0, NO_RUN);
        send_byte(8'd90, 1'b0, 1'b0, NO_RUN);
        send_byte(8'd29, 1'b1, 1'b0, NO_RUN);
        settle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: begin fg = 4'h0; bg = 4'h0; end
                1: begin fg = 4'hF; bg = 4'h0; end
                2: begin fg = 4'h0; bg = 4'hF; end
                default:
                begin
                    fg = 4'($urandom_range(0, 15));
                    bg = 4'($urandom_range(0, 15));
                end
            endcase
            program_colors(fg, bg);
            steady_send = (phase == 5);
            if (phase == 3)
            begin
                long_hold_req = 1'b1;
                steady_send   = 1'b1;
                repeat (PRESSURE_BYTES)
                    send_byte(8'($urandom_range(32, 255)), 1'b0, 1'b0, NO_RUN);
                steady_send = 1'b0;
            end
            target = bytes_sent + BYTES_PER_PHASE;
            while (bytes_sent < target)
                send_token();
            steady_send = 1'b0;
            settle();
        end

        if (!failed && runs_due.size() == 0)
            $display("PASS rle_text_screen_decoder");
        else
            $display("FAIL rle_text_screen_decoder");
        $finish;
    end

endmodule
